### hdl/seq_sorted_reorder_buffer_assert.svh
// Assertion macros for the sorted reorder buffer modules.
`ifndef SEQ_SORTED_REORDER_BUFFER_ASSERT_SVH
`define SEQ_SORTED_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/srb_pkg.sv
// Shared types and constants for the sorted reorder buffer.
package srb_pkg;

  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_DATA,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } ctl_state_e;

  typedef struct packed {
    logic    cap;
    logic    rd_en;
    logic    rd_prev;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_to_count;
    logic    pos_load;
    logic    wr_new;
    logic    wr_shift;
    logic    pop_commit;
    logic    ins_commit;
    logic    set_status;
    status_e status;
    logic    pend_load;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic kind_pop;
    logic empty;
    logic full;
    logic scan_end;
    logic seq_eq;
    logic seq_gt;
    logic shift_end;
    logic out_free;
  } dp_sts_t;

endpackage

### hdl/srb_ctrl.sv
// Sequencing state machine of the sorted reorder buffer.
module srb_ctrl
  import srb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts_i.kind_pop) begin
          state_d = sts_i.empty ? S_RESP : S_POP_DATA;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_POP_DATA: state_d = S_RESP;
      S_SCAN_RD: begin
        state_d = sts_i.scan_end ? S_PLACE : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.seq_eq) begin
          state_d = S_RESP;
        end else if (sts_i.seq_gt) begin
          state_d = S_PLACE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_PLACE: begin
        state_d = sts_i.full ? S_RESP : S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        state_d = sts_i.shift_end ? S_RESP : S_SHIFT_WR;
      end
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.status = ST_INSERTED;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        cmd_o.cap = in_valid_i;
      end
      S_DISPATCH: begin
        if (sts_i.kind_pop) begin
          if (sts_i.empty) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_EMPTY;
          end else begin
            cmd_o.rd_en = 1'b1;
          end
        end
      end
      S_POP_DATA: begin
        cmd_o.pend_load  = 1'b1;
        cmd_o.pop_commit = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = ST_POPPED;
      end
      S_SCAN_RD: begin
        if (sts_i.scan_end) begin
          cmd_o.pos_load = 1'b1;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.seq_eq) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DUPLICATE;
        end else if (sts_i.seq_gt) begin
          cmd_o.pos_load = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_PLACE: begin
        if (sts_i.full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_FULL;
        end else begin
          cmd_o.idx_to_count = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.shift_end) begin
          cmd_o.wr_new     = 1'b1;
          cmd_o.ins_commit = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_INSERTED;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_dec  = 1'b1;
      end
      S_RESP: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### hdl/srb_dp.sv
// Datapath of the sorted reorder buffer: entry ring memory, pointers, result registers.
`include "seq_sorted_reorder_buffer_assert.svh"
module srb_dp
  import srb_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   kind_i,
  input  logic [SEQ_W-1:0]       seq_no_i,
  input  logic [HANDLE_BITS-1:0] packet_handle_i,
  input  ctl_cmd_t               cmd_i,
  output dp_sts_t                sts_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [STATUS_W-1:0]    status_o,
  output logic [SEQ_W-1:0]       out_seq_no_o,
  output logic [HANDLE_BITS-1:0] out_handle_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = SEQ_W + HANDLE_BITS;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rd_data_q;

  logic [AW-1:0]          head_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          idx_q;
  logic [CW-1:0]          pos_q;
  logic                   kind_q;
  logic [SEQ_W-1:0]       seq_q;
  logic [HANDLE_BITS-1:0] handle_q;
  status_e                res_status_q;
  logic [SEQ_W-1:0]       pend_seq_q;
  logic [HANDLE_BITS-1:0] pend_handle_q;
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [SEQ_W-1:0]       out_seq_q;
  logic [HANDLE_BITS-1:0] out_handle_q;

  logic [CW-1:0]    idx_m1;
  logic [AW-1:0]    rd_off;
  logic [AW:0]      rd_sum;
  logic [AW-1:0]    rd_addr;
  logic [AW:0]      wr_sum;
  logic [AW-1:0]    wr_addr;
  logic [AW:0]      head_sum;
  logic [AW-1:0]    head_nxt;
  logic [SEQ_W-1:0] rd_seq;
  logic             out_free;

  assign idx_m1  = idx_q - CW'(1);
  assign rd_off  = cmd_i.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign rd_sum  = {1'b0, head_q} + {1'b0, rd_off};
  assign rd_addr = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : rd_sum[AW-1:0];
  assign wr_sum  = {1'b0, head_q} + {1'b0, idx_q[AW-1:0]};
  assign wr_addr = (wr_sum >= DEPTH_A) ? AW'(wr_sum - DEPTH_A) : wr_sum[AW-1:0];
  assign head_sum = {1'b0, head_q} + (AW + 1)'(1);
  assign head_nxt = (head_sum >= DEPTH_A) ? AW'(head_sum - DEPTH_A) : head_sum[AW-1:0];
  assign rd_seq  = rd_data_q[EW-1:HANDLE_BITS];
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_new) begin
      mem_q[wr_addr] <= {seq_q, handle_q};
    end else if (cmd_i.wr_shift) begin
      mem_q[wr_addr] <= rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.pop_commit) begin
        head_q  <= head_nxt;
        count_q <= count_q - CW'(1);
      end else if (cmd_i.ins_commit) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q   <= kind_i;
      seq_q    <= seq_no_i;
      handle_q <= packet_handle_i;
      idx_q    <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + CW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_m1;
    end else if (cmd_i.idx_to_count) begin
      idx_q <= count_q;
    end
    if (cmd_i.pos_load) begin
      pos_q <= idx_q;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.pend_load) begin
      pend_seq_q    <= rd_seq;
      pend_handle_q <= rd_data_q[HANDLE_BITS-1:0];
    end
    if (cmd_i.out_load) begin
      status_q <= res_status_q;
      if (res_status_q == ST_POPPED) begin
        out_seq_q    <= pend_seq_q;
        out_handle_q <= pend_handle_q;
      end else begin
        out_seq_q    <= '0;
        out_handle_q <= '0;
      end
    end
  end

  always_comb begin
    sts_o.kind_pop  = kind_q;
    sts_o.empty     = (count_q == '0);
    sts_o.full      = (count_q == DEPTH_C);
    sts_o.scan_end  = (idx_q == count_q);
    sts_o.seq_eq    = (rd_seq == seq_q);
    sts_o.seq_gt    = (rd_seq > seq_q);
    sts_o.shift_end = (idx_q == pos_q);
    sts_o.out_free  = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_seq_no_o = out_seq_q;
  assign out_handle_o = out_handle_q;

  `SRB_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DEPTH_C, "fill count above depth")
  `SRB_ASSERT_NOW(a_ins_not_full, cmd_i.ins_commit, count_q != DEPTH_C, "insert into full buffer")
  `SRB_ASSERT_NOW(a_pop_not_empty, cmd_i.pop_commit, count_q != '0, "pop from empty buffer")
  `SRB_ASSERT_NOW(a_load_free, cmd_i.out_load, !out_valid_q || !out_stall_i,
                  "result overwritten while stalled")
  `SRB_ASSERT_NEXT(a_pop_moves_head, cmd_i.pop_commit, head_q == $past(head_nxt),
                   "head did not advance on pop")

endmodule

### hdl/seq_sorted_reorder_buffer.sv
// Pop: request to result register through states DISPATCH, POP_DATA and RESP; POP_DATA is skipped when empty.
// Insert time is set by the scan and the tail shift through the one-port-read entry memory,
// each stepping entry by entry; one request is in work at a time.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous) empties the buffer and clears the output valid;
// entry memory contents are not cleared.
module seq_sorted_reorder_buffer
  import srb_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   kind_i,
  input  logic [SEQ_W-1:0]       seq_no_i,
  input  logic [HANDLE_BITS-1:0] packet_handle_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [SEQ_W-1:0]       out_seq_no_o,
  output logic [HANDLE_BITS-1:0] out_handle_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  srb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srb_dp #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .kind_i          (kind_i),
    .seq_no_i        (seq_no_i),
    .packet_handle_i (packet_handle_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .out_seq_no_o    (out_seq_no_o),
    .out_handle_o    (out_handle_o)
  );

endmodule
